### rtl/core/si_pkg.sv
// Shared constants and types for the segment intersection block.
package si_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int OUT_W           = 24;
    localparam int OUT_DATA_W      = ((1 + 2 * OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic ok;
        logic neg_x;
        logic neg_y;
    } t_si_ctl;

endpackage

### rtl/core/si_front.sv
// Front stages: line equations, side tests, determinant and numerators.
module si_front import si_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF,
    localparam int DENW = 2 * CW + 3,
    localparam int QW   = CW + FB + 2,
    localparam int BW   = 8 * CW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [8*CW-1:0] i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output t_si_ctl         o_ctl,
    output logic [DENW-1:0] o_den,
    output logic [DENW-1:0] o_rem_x,
    output logic [DENW-1:0] o_rem_y,
    output logic [QW-1:0]   o_nb_x,
    output logic [QW-1:0]   o_nb_y,
    output logic [BW-1:0]   o_box
);

    localparam int DIFW  = CW + 1;
    localparam int CW2   = 2 * CW + 1;
    localparam int SIDEW = 2 * CW + 4;
    localparam int PRW   = 3 * CW + 2;
    localparam int NUMW  = 3 * CW + 4;
    localparam int NMW   = NUMW + FB;

    logic en1, en2, en3;

    // stage 1
    logic                   r1_v;
    logic signed [CW-1:0]   r1_x [0:3];
    logic signed [CW-1:0]   r1_y [0:3];
    logic signed [DIFW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [CW2-1:0]  r1_c1, r1_c2;
    logic signed [CW-1:0]   w_x [0:3];
    logic signed [CW-1:0]   w_y [0:3];

    // stage 2
    logic                    r2_v;
    logic signed [CW-1:0]    r2_x [0:3];
    logic signed [CW-1:0]    r2_y [0:3];
    logic signed [SIDEW-1:0] r2_s1a, r2_s1b, r2_s2a, r2_s2b;
    logic signed [DENW-1:0]  r2_den;
    logic signed [PRW-1:0]   r2_px1, r2_px2, r2_py1, r2_py2;

    // stage 3
    logic                   r3_v;
    t_si_ctl                r3_ctl;
    logic [DENW-1:0]        r3_den, r3_rem_x, r3_rem_y;
    logic [QW-1:0]          r3_nb_x, r3_nb_y;
    logic [BW-1:0]          r3_box;

    logic signed [NUMW-1:0] numx, numy;
    logic [NUMW-1:0]        nxm, nym;
    logic [NMW-1:0]         nsx, nsy;
    logic [DENW-1:0]        denm;
    logic                   side1, side2;
    logic [BW-1:0]          box;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    for (genvar k = 0; k < 4; k++) begin : g_unpack
        assign w_x[k] = $signed(i_data[(2*k)*CW +: CW]);
        assign w_y[k] = $signed(i_data[(2*k+1)*CW +: CW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x  <= w_x;
            r1_y  <= w_y;
            r1_a1 <= DIFW'(w_y[1]) - DIFW'(w_y[0]);
            r1_b1 <= DIFW'(w_x[0]) - DIFW'(w_x[1]);
            r1_a2 <= DIFW'(w_y[3]) - DIFW'(w_y[2]);
            r1_b2 <= DIFW'(w_x[2]) - DIFW'(w_x[3]);
            r1_c1 <= CW2'(w_x[1]) * CW2'(w_y[0]) - CW2'(w_x[0]) * CW2'(w_y[1]);
            r1_c2 <= CW2'(w_x[3]) * CW2'(w_y[2]) - CW2'(w_x[2]) * CW2'(w_y[3]);
        end
        if (en2) begin
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_s1a <= SIDEW'(r1_a1) * SIDEW'(r1_x[2]) + SIDEW'(r1_b1) * SIDEW'(r1_y[2])
                    + SIDEW'(r1_c1);
            r2_s1b <= SIDEW'(r1_a1) * SIDEW'(r1_x[3]) + SIDEW'(r1_b1) * SIDEW'(r1_y[3])
                    + SIDEW'(r1_c1);
            r2_s2a <= SIDEW'(r1_a2) * SIDEW'(r1_x[0]) + SIDEW'(r1_b2) * SIDEW'(r1_y[0])
                    + SIDEW'(r1_c2);
            r2_s2b <= SIDEW'(r1_a2) * SIDEW'(r1_x[1]) + SIDEW'(r1_b2) * SIDEW'(r1_y[1])
                    + SIDEW'(r1_c2);
            r2_den <= DENW'(r1_a1) * DENW'(r1_b2) - DENW'(r1_a2) * DENW'(r1_b1);
            r2_px1 <= PRW'(r1_b1) * PRW'(r1_c2);
            r2_px2 <= PRW'(r1_b2) * PRW'(r1_c1);
            r2_py1 <= PRW'(r1_a2) * PRW'(r1_c1);
            r2_py2 <= PRW'(r1_a1) * PRW'(r1_c2);
        end
    end

    // box limits: lo/hi x, lo/hi y of segment a, then of segment b
    for (genvar s = 0; s < 2; s++) begin : g_box
        assign box[(4*s+0)*CW +: CW] = (r2_x[2*s] < r2_x[2*s+1]) ? r2_x[2*s] : r2_x[2*s+1];
        assign box[(4*s+1)*CW +: CW] = (r2_x[2*s] < r2_x[2*s+1]) ? r2_x[2*s+1] : r2_x[2*s];
        assign box[(4*s+2)*CW +: CW] = (r2_y[2*s] < r2_y[2*s+1]) ? r2_y[2*s] : r2_y[2*s+1];
        assign box[(4*s+3)*CW +: CW] = (r2_y[2*s] < r2_y[2*s+1]) ? r2_y[2*s+1] : r2_y[2*s];
    end

    always_comb begin
        numx  = NUMW'(r2_px1) - NUMW'(r2_px2);
        numy  = NUMW'(r2_py1) - NUMW'(r2_py2);
        nxm   = numx[NUMW-1] ? NUMW'(-numx) : NUMW'(numx);
        nym   = numy[NUMW-1] ? NUMW'(-numy) : NUMW'(numy);
        denm  = r2_den[DENW-1] ? DENW'(-r2_den) : DENW'(r2_den);
        nsx   = NMW'(nxm) << FB;
        nsy   = NMW'(nym) << FB;
        side1 = (r2_s1a == '0) || (r2_s1b == '0) || (r2_s1a[SIDEW-1] != r2_s1b[SIDEW-1]);
        side2 = (r2_s2a == '0) || (r2_s2b == '0) || (r2_s2a[SIDEW-1] != r2_s2b[SIDEW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_ctl.ok    <= side1 && side2 && (r2_den != '0);
            r3_ctl.neg_x <= numx[NUMW-1] ^ r2_den[DENW-1];
            r3_ctl.neg_y <= numy[NUMW-1] ^ r2_den[DENW-1];
            r3_den       <= denm;
            r3_rem_x     <= DENW'(nsx[NMW-1:QW]);
            r3_rem_y     <= DENW'(nsy[NMW-1:QW]);
            r3_nb_x      <= nsx[QW-1:0];
            r3_nb_y      <= nsy[QW-1:0];
            r3_box       <= box;
        end
    end

    assign o_valid = r3_v;
    assign o_ctl   = r3_ctl;
    assign o_den   = r3_den;
    assign o_rem_x = r3_rem_x;
    assign o_rem_y = r3_rem_y;
    assign o_nb_x  = r3_nb_x;
    assign o_nb_y  = r3_nb_y;
    assign o_box   = r3_box;

endmodule

### rtl/core/si_cell.sv
// One restoring-division cell: resolves one quotient bit for x and y.
module si_cell import si_pkg::*; #(
    parameter int QW = 26,
    parameter int DW = 35,
    parameter int BW = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_si_ctl       i_ctl,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem_x,
    input  logic [DW-1:0] i_rem_y,
    input  logic [QW-1:0] i_nb_x,
    input  logic [QW-1:0] i_nb_y,
    input  logic [QW-1:0] i_q_x,
    input  logic [QW-1:0] i_q_y,
    input  logic [BW-1:0] i_box,
    output logic          o_valid,
    input  logic          i_ready,
    output t_si_ctl       o_ctl,
    output logic [DW-1:0] o_den,
    output logic [DW-1:0] o_rem_x,
    output logic [DW-1:0] o_rem_y,
    output logic [QW-1:0] o_nb_x,
    output logic [QW-1:0] o_nb_y,
    output logic [QW-1:0] o_q_x,
    output logic [QW-1:0] o_q_y,
    output logic [BW-1:0] o_box
);

    logic          r_v;
    t_si_ctl       r_ctl;
    logic [DW-1:0] r_den, r_rem_x, r_rem_y;
    logic [QW-1:0] r_nb_x, r_nb_y, r_q_x, r_q_y;
    logic [BW-1:0] r_box;
    logic [DW:0]   tx, ty;
    logic          gx, gy;
    logic          en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;

    always_comb begin
        tx = {i_rem_x, i_nb_x[QW-1]};
        ty = {i_rem_y, i_nb_y[QW-1]};
        gx = tx >= {1'b0, i_den};
        gy = ty >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl   <= i_ctl;
            r_den   <= i_den;
            r_rem_x <= gx ? DW'(tx - {1'b0, i_den}) : DW'(tx);
            r_rem_y <= gy ? DW'(ty - {1'b0, i_den}) : DW'(ty);
            r_nb_x  <= i_nb_x << 1;
            r_nb_y  <= i_nb_y << 1;
            r_q_x   <= {i_q_x[QW-2:0], gx};
            r_q_y   <= {i_q_y[QW-2:0], gy};
            r_box   <= i_box;
        end
    end

    assign o_valid = r_v;
    assign o_ctl   = r_ctl;
    assign o_den   = r_den;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_nb_x  = r_nb_x;
    assign o_nb_y  = r_nb_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_box   = r_box;

endmodule

### rtl/core/si_back.sv
// Back stage: signs the quotients, checks both boxes, holds the result item.
module si_back import si_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF,
    localparam int QW = CW + FB + 2,
    localparam int BW = 8 * CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_si_ctl               i_ctl,
    input  logic [QW-1:0]         i_q_x,
    input  logic [QW-1:0]         i_q_y,
    input  logic [BW-1:0]         i_box,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int PW = QW + 1;

    logic                 r_v, r_hit;
    logic [OUT_W-1:0]     r_x, r_y;
    logic signed [PW-1:0] px, py;
    logic                 hit, en;

    function automatic logic signed [PW-1:0] fx(input logic [CW-1:0] v);
        fx = PW'($signed(v)) <<< FB;
    endfunction

    assign en      = !r_v || i_ready;
    assign o_ready = en;

    always_comb begin
        px  = i_ctl.neg_x ? -$signed({1'b0, i_q_x}) : $signed({1'b0, i_q_x});
        py  = i_ctl.neg_y ? -$signed({1'b0, i_q_y}) : $signed({1'b0, i_q_y});
        hit = i_ctl.ok;
        for (int s = 0; s < 2; s++) begin
            if (px < fx(i_box[(4*s+0)*CW +: CW]) || px > fx(i_box[(4*s+1)*CW +: CW]) ||
                py < fx(i_box[(4*s+2)*CW +: CW]) || py > fx(i_box[(4*s+3)*CW +: CW]))
                hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= hit;
            r_x   <= hit ? OUT_W'(px) : '0;
            r_y   <= hit ? OUT_W'(py) : '0;
        end
    end

    assign o_valid = r_v;
    assign o_data  = OUT_DATA_W'({r_y, r_x, r_hit});

endmodule

### rtl/core/segment_intersection.sv
// Top level of the 2D segment intersection pipeline.
// The block takes one pair of segments per item and returns one result item per input:
// a hit flag and the crossing point in signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero, or all zeros on a miss (same side, parallel or outside a box).
// It accepts one item every cycle while the output is not stalled; three front stages
// build the line equations, side tests and numerators, then a row of COORD_WIDTH +
// FRAC_BITS + 2 division cells each settles one quotient bit of x and y, and a final
// stage applies signs, checks the bounding boxes and holds the result item. Every
// stage empties into the next one on its own, so a stalled output only stops the pipe
// once every stage holds an item.
module segment_intersection import si_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // hit, cross_x, cross_y, zero pad
    output logic [OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int DENW = 2 * COORD_WIDTH + 3;
    localparam int QW   = COORD_WIDTH + FRAC_BITS + 2;
    localparam int BW   = 8 * COORD_WIDTH;

    // connections along the row of division cells; index 0 is the front stage output
    logic            w_v     [0:QW];
    logic            w_rdy   [0:QW];
    t_si_ctl         w_ctl   [0:QW];
    logic [DENW-1:0] w_den   [0:QW];
    logic [DENW-1:0] w_rem_x [0:QW];
    logic [DENW-1:0] w_rem_y [0:QW];
    logic [QW-1:0]   w_nb_x  [0:QW];
    logic [QW-1:0]   w_nb_y  [0:QW];
    logic [QW-1:0]   w_q_x   [0:QW];
    logic [QW-1:0]   w_q_y   [0:QW];
    logic [BW-1:0]   w_box   [0:QW];

    si_front #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_ctl   (w_ctl[0]),
        .o_den   (w_den[0]),
        .o_rem_x (w_rem_x[0]),
        .o_rem_y (w_rem_y[0]),
        .o_nb_x  (w_nb_x[0]),
        .o_nb_y  (w_nb_y[0]),
        .o_box   (w_box[0])
    );

    // quotients start empty; each cell shifts in one bit
    assign w_q_x[0] = '0;
    assign w_q_y[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        si_cell #(.QW(QW), .DW(DENW), .BW(BW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_ctl   (w_ctl[k]),
            .i_den   (w_den[k]),
            .i_rem_x (w_rem_x[k]),
            .i_rem_y (w_rem_y[k]),
            .i_nb_x  (w_nb_x[k]),
            .i_nb_y  (w_nb_y[k]),
            .i_q_x   (w_q_x[k]),
            .i_q_y   (w_q_y[k]),
            .i_box   (w_box[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_den   (w_den[k+1]),
            .o_rem_x (w_rem_x[k+1]),
            .o_rem_y (w_rem_y[k+1]),
            .o_nb_x  (w_nb_x[k+1]),
            .o_nb_y  (w_nb_y[k+1]),
            .o_q_x   (w_q_x[k+1]),
            .o_q_y   (w_q_y[k+1]),
            .o_box   (w_box[k+1])
        );
    end

    si_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[QW]),
        .o_ready (w_rdy[QW]),
        .i_ctl   (w_ctl[QW]),
        .i_q_x   (w_q_x[QW]),
        .i_q_y   (w_q_y[QW]),
        .i_box   (w_box[QW]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2*OUT_W:1] == '0)
        else $error("miss item with nonzero point");

    // input side only stalls when the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // pipe is empty right after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

### tb/sv/si_checker.sv
// Checker for the segment intersection block: predicts and compares every result item.
module si_checker import si_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [127:0]          i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic              hit;
        logic [OUT_W-1:0]  cross_x;
        logic [OUT_W-1:0]  cross_y;
    } crossing_t;

    crossing_t crossings_due[$];

    function automatic logic straddles(logic signed [127:0] p, logic signed [127:0] q);
        return (p == 0) || (q == 0) || ((p < 0) != (q < 0));
    endfunction

    function automatic logic in_box(logic signed [127:0] x, logic signed [127:0] y,
                                    logic signed [127:0] xa, logic signed [127:0] ya,
                                    logic signed [127:0] xb, logic signed [127:0] yb);
        logic signed [127:0] lox, hix, loy, hiy;
        lox = ((xa < xb) ? xa : xb) <<< FB;
        hix = ((xa < xb) ? xb : xa) <<< FB;
        loy = ((ya < yb) ? ya : yb) <<< FB;
        hiy = ((ya < yb) ? yb : ya) <<< FB;
        return x >= lox && x <= hix && y >= loy && y <= hiy;
    endfunction

    // Exact crossing point of the two segments, or a miss with zero coordinates.
    function automatic crossing_t crossing_of(logic [127:0] d);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] a1, b1, c1, a2, b2, c2, den, px, py, lim;
        crossing_t r;
        r  = '0;
        x1 = $signed(d[15:0]);    y1 = $signed(d[31:16]);
        x2 = $signed(d[47:32]);   y2 = $signed(d[63:48]);
        x3 = $signed(d[79:64]);   y3 = $signed(d[95:80]);
        x4 = $signed(d[111:96]);  y4 = $signed(d[127:112]);
        a1 = y2 - y1;  b1 = x1 - x2;  c1 = x2 * y1 - x1 * y2;
        if (!straddles(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1)) return r;
        a2 = y4 - y3;  b2 = x3 - x4;  c2 = x4 * y3 - x3 * y4;
        if (!straddles(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2)) return r;
        den = a1 * b2 - a2 * b1;
        if (den == 0) return r;
        // signed division truncates toward zero
        px  = ((b1 * c2 - b2 * c1) <<< FB) / den;
        py  = ((a2 * c1 - a1 * c2) <<< FB) / den;
        lim = 128'sd1 <<< 62;
        if (px > lim || px < -lim || py > lim || py < -lim) return r;
        if (in_box(px, py, x1, y1, x2, y2) && in_box(px, py, x3, y3, x4, y4)) begin
            r.hit     = 1'b1;
            r.cross_x = px[OUT_W-1:0];
            r.cross_y = py[OUT_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        crossing_t want, got;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                crossings_due.insert(crossings_due.size(), crossing_of(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.hit     = i_m_tdata[0];
                got.cross_x = i_m_tdata[OUT_W:1];
                got.cross_y = i_m_tdata[2*OUT_W:OUT_W+1];
                if (crossings_due.size() == 0) begin
                    $display("%0t: result item with none expected: %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = crossings_due.pop_front();
                    if (got.hit !== want.hit || got.cross_x !== want.cross_x
                            || got.cross_y !== want.cross_y || i_m_tdata[55:49] !== '0) begin
                        $display("%0t: mismatch hit/x/y expected %b %h %h actual %b %h %h",
                                 $time, want.hit, want.cross_x, want.cross_y,
                                 got.hit, got.cross_x, got.cross_y);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= crossings_due.size();
        end
    end
endmodule

### tb/sv/tb_top.sv
// Stimulus, clock, reset and verdict for the segment intersection testbench.
module tb_top import si_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 30;
    localparam int N_RANDOM  = 600;
    localparam int LIMIT     = 200000;
    localparam int HOLD_LEN  = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [127:0]          s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    errors;
    int                    pending;
    int                    cycles = 0;
    int                    sent = 0;
    logic                  hold_off_req = 1'b0;

    segment_intersection u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    si_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always #6 i_clk = ~i_clk;

    // Bail out if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // No idling inside this stretch of items.
    function automatic logic busy_window();
        return sent >= 250 && sent < 380;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                for (n = 0; n < HOLD_LEN; n++) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            m_tready = busy_window() ? 1'b1 : ($urandom_range(0, 99) >= 19);
        end
    end

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Pack the eight endpoint coordinates, a_start_x in the lowest bits.
    function automatic logic [127:0] segments(int ax0, int ay0, int ax1, int ay1,
                                              int bx0, int by0, int bx1, int by1);
        return {clamp16(by1), clamp16(bx1), clamp16(by0), clamp16(bx0),
                clamp16(ay1), clamp16(ax1), clamp16(ay0), clamp16(ax0)};
    endfunction

    // Offer one item, with random gaps in front of it, until it is taken.
    task automatic send(logic [127:0] d);
        while (!busy_window() && $urandom_range(0, 99) < 19) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        sent++;
        s_tvalid = 1'b0;
    endtask

    // Local segments near a random center: hits, touches and misses are all common.
    function automatic logic [127:0] local_pair();
        int cx, cy, w;
        cx = $urandom_range(0, 60000) - 30000;
        cy = $urandom_range(0, 60000) - 30000;
        w  = ($urandom_range(0, 3) == 0) ? 2700 : 40;
        return segments(cx + $urandom_range(0, 2*w) - w, cy + $urandom_range(0, 2*w) - w,
                        cx + $urandom_range(0, 2*w) - w, cy + $urandom_range(0, 2*w) - w,
                        cx + $urandom_range(0, 2*w) - w, cy + $urandom_range(0, 2*w) - w,
                        cx + $urandom_range(0, 2*w) - w, cy + $urandom_range(0, 2*w) - w);
    endfunction

    initial begin
        int i;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: a clean X crossing and its mirror
        send(segments(-10, -10, 10, 10, -10, 10, 10, -10));
        send(segments(10, 10, -10, -10, 10, -10, -10, 10));
        // crossing with a fractional point
        send(segments(0, 0, 3, 1, 0, 1, 2, 0));
        // negative fractions, truncation toward zero
        send(segments(0, 0, -3, -1, 0, -1, -2, 0));
        // same side
        send(segments(0, 0, 10, 0, 0, 1, 10, 5));
        // parallel and collinear
        send(segments(0, 0, 10, 10, 0, 1, 10, 11));
        send(segments(0, 0, 10, 10, 5, 5, 20, 20));
        // touching at an endpoint, T junction
        send(segments(0, 0, 10, 0, 10, 0, 10, 10));
        send(segments(0, 0, 10, 0, 5, 0, 5, 7));
        // lines cross outside a box
        send(segments(0, 0, 1, 1, 5, 0, 4, 1));
        // degenerate: points
        send(segments(3, 3, 3, 3, 3, 3, 3, 3));
        send(segments(0, 0, 0, 0, -5, 0, 5, 0));
        // extremes of the coordinate range
        send(segments(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send(segments(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send(segments(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send(segments(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        send({128{1'b1}});
        send('0);
        send({8{16'h8000}});
        send({8{16'h7fff}});

        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 100) hold_off_req = 1'b1;
            if (i == 450) begin
                // pause the sender until every result item is back
                while (pending != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) < 20)
                send({$urandom, $urandom, $urandom, $urandom});
            else
                send(local_pair());
        end

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### sim.f
rtl/core/si_pkg.sv
rtl/core/si_front.sv
rtl/core/si_cell.sv
rtl/core/si_back.sv
rtl/core/segment_intersection.sv
tb/sv/si_checker.sv
tb/sv/tb_top.sv
